/* design/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// dfs_pkg: shared types for the delimited field selector
// Word formats, result kinds, register indexes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int POS_W      = 16;
  localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
    logic       empty_line;
  } in_item_t;

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_LINE_END   = 2'd1,
    KIND_SUPPRESSED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       truncated;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_FIELD_MODE  = 3'd0,
    REG_IN_DELIM    = 3'd1,
    REG_OUT_DELIM   = 3'd2,
    REG_SUPPRESS    = 3'd3,
    REG_SELECT_MASK = 3'd4,
    REG_OPEN_START  = 3'd5,
    REG_RANGE_LOW   = 3'd6,
    REG_RANGE_HIGH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic             field_mode;
    logic [7:0]       in_delimiter;
    logic [7:0]       out_delimiter;
    logic             suppress_plain;
    logic [POS_W-1:0] open_start;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_FLUSH_RD = 3'd1,
    ST_FLUSH_WR = 3'd2,
    ST_TAIL_R1  = 3'd3,
    ST_TAIL_R2  = 3'd4
  } state_t;

  // source of the word loaded into the output register
  typedef enum logic [2:0] {
    SRC_NEW_R1  = 3'd0,
    SRC_NEW_R2  = 3'd1,
    SRC_FLUSH   = 3'd2,
    SRC_PLAN_R1 = 3'd3,
    SRC_PLAN_R2 = 3'd4
  } src_t;

  typedef struct packed {
    logic accept;
    logic load;
    src_t src;
    logic last;
    logic rd_first;
    logic rd_next;
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic has_flush;
    logic has_r1;
    logic has_r2;
    logic plan_r1;
    logic plan_r2;
    logic flush_last;
  } status_t;

endpackage

`default_nettype wire

/* design/dfs_ram.sv */
// ----------------------------------------------------------------------------
// dfs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/dfs_regs.sv */
// ----------------------------------------------------------------------------
// dfs_regs: configuration register file
// APB-style write/read access to the selector's mode and selection registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_regs
  import dfs_pkg::*;
#(
  parameter int MASK_POSITIONS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [CFG_ADDR_W-1:0]     paddr,
  input  wire logic [CFG_DATA_W-1:0]     pwdata,
  output logic      [CFG_DATA_W-1:0]     prdata,
  output logic                           pready,
  output cfg_t                           cfg,
  output logic      [MASK_POSITIONS-1:0] mask
);

  cfg_t                      cfg_r, cfg_nxt;
  logic [MASK_POSITIONS-1:0] mask_r, mask_nxt;
  logic                      wr;
  reg_idx_t                  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

  always_comb begin
    cfg_nxt  = cfg_r;
    mask_nxt = mask_r;
    if (wr) begin
      unique case (idx)
        REG_FIELD_MODE:  cfg_nxt.field_mode     = pwdata[0];
        REG_IN_DELIM:    cfg_nxt.in_delimiter   = pwdata[7:0];
        REG_OUT_DELIM:   cfg_nxt.out_delimiter  = pwdata[7:0];
        REG_SUPPRESS:    cfg_nxt.suppress_plain = pwdata[0];
        REG_SELECT_MASK: mask_nxt               = pwdata[MASK_POSITIONS-1:0];
        REG_OPEN_START:  cfg_nxt.open_start     = pwdata[POS_W-1:0];
        REG_RANGE_LOW:   cfg_nxt.range_low      = pwdata[POS_W-1:0];
        REG_RANGE_HIGH:  cfg_nxt.range_high     = pwdata[POS_W-1:0];
        default:         cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_mode     <= 1'b0;
      cfg_r.in_delimiter   <= 8'd9;
      cfg_r.out_delimiter  <= 8'd9;
      cfg_r.suppress_plain <= 1'b0;
      cfg_r.open_start     <= '0;
      cfg_r.range_low      <= '0;
      cfg_r.range_high     <= '0;
      mask_r               <= '0;
    end else begin
      cfg_r  <= cfg_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIELD_MODE:  prdata = CFG_DATA_W'(cfg_r.field_mode);
      REG_IN_DELIM:    prdata = CFG_DATA_W'(cfg_r.in_delimiter);
      REG_OUT_DELIM:   prdata = CFG_DATA_W'(cfg_r.out_delimiter);
      REG_SUPPRESS:    prdata = CFG_DATA_W'(cfg_r.suppress_plain);
      REG_SELECT_MASK: prdata = CFG_DATA_W'(mask_r);
      REG_OPEN_START:  prdata = CFG_DATA_W'(cfg_r.open_start);
      REG_RANGE_LOW:   prdata = CFG_DATA_W'(cfg_r.range_low);
      REG_RANGE_HIGH:  prdata = CFG_DATA_W'(cfg_r.range_high);
      default:         prdata = '0;
    endcase
  end

  assign cfg  = cfg_r;
  assign mask = mask_r;

endmodule

`default_nettype wire

/* design/dfs_datapath.sv */
// ----------------------------------------------------------------------------
// dfs_datapath: line state, first-field buffer and output register
// Decodes each input word into a result plan (buffer flush, one byte or
// delimiter, line marker), keeps the plan and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_datapath
  import dfs_pkg::*;
#(
  parameter int MASK_POSITIONS    = 64,
  parameter int FIRST_FIELD_DEPTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cfg_t                      cfg,
  input  wire logic [MASK_POSITIONS-1:0] mask,
  input  wire in_item_t                  in_data,
  input  wire cmd_t                      cmd,
  output status_t                        status,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_data
);

  localparam int FW  = $clog2(FIRST_FIELD_DEPTH + 1);
  localparam int AW  = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;
  localparam int MIW = $clog2(MASK_POSITIONS);

  // line state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             emitted_r, emitted_nxt;
  logic             dseen_r, dseen_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;

  // plan of the word being drained
  logic [FW-1:0]    pflush_n_r;
  logic             pr1_v_r;
  logic [7:0]       pr1_byte_r;
  logic             pr2_v_r;
  kind_t            pr2_kind_r;
  logic             ptrunc_r;
  logic [AW-1:0]    idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  // decode of the incoming word
  logic             has_byte, eol, is_delim, is_plain, buf_full;
  logic [POS_W-1:0] pos_inc;
  logic             sel_cur, sel_nxt;
  logic             store_wr, flush, flush_a, r1_v, r2_v;
  logic [7:0]       r1_byte;
  kind_t            r2_kind;
  logic             ovf_after, dseen_after, emitted_after;
  logic [FW-1:0]    fill_after;
  logic [POS_W-1:0] pos_after;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  function automatic logic pos_selected(input logic [POS_W-1:0] p);
    logic by_open, by_mask, by_range;
    begin
      by_open  = (cfg.open_start != '0) && (p >= cfg.open_start);
      by_mask  = (p != '0) && (p <= POS_W'(MASK_POSITIONS)) && mask[MIW'(p - 16'd1)];
      by_range = (p >= cfg.range_low) && (p <= cfg.range_high);
      pos_selected = by_open || by_mask || by_range;
    end
  endfunction

  assign has_byte = !in_data.empty_line;
  assign eol      = in_data.end_of_line || in_data.empty_line;
  assign is_delim = has_byte && (in_data.data_byte == cfg.in_delimiter);
  assign is_plain = has_byte && !is_delim;
  assign buf_full = (fill_r == FW'(FIRST_FIELD_DEPTH));
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;

  // re-evaluated on register changes too, not only on position changes
  always_comb begin
    sel_cur = pos_selected(pos_r);
    sel_nxt = pos_selected(pos_inc);
  end

  always_comb begin
    store_wr      = 1'b0;
    flush_a       = 1'b0;
    flush         = 1'b0;
    r1_v          = 1'b0;
    r1_byte       = in_data.data_byte;
    r2_v          = eol;
    r2_kind       = KIND_LINE_END;
    ovf_after     = ovf_r;
    fill_after    = fill_r;
    dseen_after   = dseen_r;
    emitted_after = emitted_r;
    pos_after     = pos_r;
    if (cfg.field_mode) begin
      // first delimiter of a line releases the buffered first field when field 1 is selected
      flush_a       = is_delim && !dseen_r && sel_cur;
      emitted_after = emitted_r || flush_a;
      if (is_delim) begin
        pos_after   = pos_inc;
        dseen_after = 1'b1;
        if (sel_nxt) begin
          r1_v          = emitted_after;
          r1_byte       = cfg.out_delimiter;
          emitted_after = 1'b1;
        end
      end
      if (is_plain && !dseen_r) begin
        if (!buf_full) begin
          store_wr   = 1'b1;
          fill_after = fill_r + FW'(1);
        end else begin
          ovf_after = 1'b1;
        end
      end
      if (is_plain && dseen_r && sel_cur) begin
        r1_v = 1'b1;
      end
      // line without delimiter: verbatim or suppressed
      if (eol && !dseen_after) begin
        if (cfg.suppress_plain) begin
          r2_kind = KIND_SUPPRESSED;
        end else begin
          flush = (fill_after != '0);
        end
      end
      if (flush_a && (fill_after != '0)) begin
        flush = 1'b1;
      end
    end else begin
      r1_v = has_byte && sel_cur;
      if (has_byte) begin
        pos_after = pos_inc;
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    emitted_nxt = emitted_r;
    dseen_nxt   = dseen_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    if (cmd.accept) begin
      if (eol) begin
        pos_nxt     = 16'd1;
        emitted_nxt = 1'b0;
        dseen_nxt   = 1'b0;
        fill_nxt    = '0;
        ovf_nxt     = 1'b0;
      end else begin
        pos_nxt     = pos_after;
        emitted_nxt = emitted_after;
        dseen_nxt   = dseen_after;
        fill_nxt    = fill_after;
        ovf_nxt     = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'd1;
      emitted_r <= 1'b0;
      dseen_r   <= 1'b0;
      fill_r    <= '0;
      ovf_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      emitted_r <= emitted_nxt;
      dseen_r   <= dseen_nxt;
      fill_r    <= fill_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pflush_n_r <= fill_after;
      pr1_v_r    <= r1_v;
      pr1_byte_r <= r1_byte;
      pr2_v_r    <= r2_v;
      pr2_kind_r <= r2_kind;
      ptrunc_r   <= ovf_after;
    end
  end

  // flush read pointer
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.rd_first) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign rd_en   = cmd.rd_first || cmd.rd_next;
  assign rd_addr = idx_nxt;

  dfs_ram #(
    .WIDTH(8),
    .DEPTH(FIRST_FIELD_DEPTH),
    .AW   (AW)
  ) u_buf (
    .clk    (clk),
    .wr_en  (cmd.accept && store_wr),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(in_data.data_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output register
  always_comb begin
    out_nxt = out_r;
    if (cmd.load) begin
      case (cmd.src)
        SRC_NEW_R1:  out_nxt = '{out_byte: r1_byte, kind: KIND_BYTE,
                                 truncated: ovf_after, last: cmd.last};
        SRC_NEW_R2:  out_nxt = '{out_byte: 8'd0, kind: r2_kind,
                                 truncated: ovf_after, last: cmd.last};
        SRC_FLUSH:   out_nxt = '{out_byte: rd_data, kind: KIND_BYTE,
                                 truncated: ptrunc_r, last: cmd.last};
        SRC_PLAN_R1: out_nxt = '{out_byte: pr1_byte_r, kind: KIND_BYTE,
                                 truncated: ptrunc_r, last: cmd.last};
        SRC_PLAN_R2: out_nxt = '{out_byte: 8'd0, kind: pr2_kind_r,
                                 truncated: ptrunc_r, last: cmd.last};
        default:     out_nxt = out_r;
      endcase
    end
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign status.load_ok    = !out_valid_r || !out_stall;
  assign status.has_flush  = flush;
  assign status.has_r1     = r1_v;
  assign status.has_r2     = r2_v;
  assign status.plan_r1    = pr1_v_r;
  assign status.plan_r2    = pr2_v_r;
  assign status.flush_last = ((FW'(idx_r) + FW'(1)) == pflush_n_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* design/dfs_ctrl.sv */
// ----------------------------------------------------------------------------
// dfs_ctrl: sequencing controller
// Accepts a word, then issues the loads of its results in order: buffered
// first field, the byte or delimiter, the line marker.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_ctrl
  import dfs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = !((state_r == ST_IDLE) && status.load_ok);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.src      = SRC_NEW_R1;
    cmd.accept   = in_valid && !in_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (status.has_flush) begin
            state_nxt = ST_FLUSH_RD;
          end else if (status.has_r1) begin
            cmd.load = 1'b1;
            cmd.src  = SRC_NEW_R1;
            cmd.last = !status.has_r2;
            if (status.has_r2) begin
              state_nxt = ST_TAIL_R2;
            end
          end else if (status.has_r2) begin
            cmd.load = 1'b1;
            cmd.src  = SRC_NEW_R2;
            cmd.last = 1'b1;
          end
        end
      end
      ST_FLUSH_RD: begin
        // first read follows the accepting edge, which may have written the last byte
        cmd.rd_first = 1'b1;
        state_nxt    = ST_FLUSH_WR;
      end
      ST_FLUSH_WR: begin
        if (status.load_ok) begin
          cmd.load = 1'b1;
          cmd.src  = SRC_FLUSH;
          if (status.flush_last) begin
            cmd.last = !status.plan_r1 && !status.plan_r2;
            if (status.plan_r1) begin
              state_nxt = ST_TAIL_R1;
            end else if (status.plan_r2) begin
              state_nxt = ST_TAIL_R2;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // fetch the next buffered byte while this one is loaded
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_TAIL_R1: begin
        if (status.load_ok) begin
          cmd.load  = 1'b1;
          cmd.src   = SRC_PLAN_R1;
          cmd.last  = !status.plan_r2;
          state_nxt = status.plan_r2 ? ST_TAIL_R2 : ST_IDLE;
        end
      end
      ST_TAIL_R2: begin
        if (status.load_ok) begin
          cmd.load  = 1'b1;
          cmd.src   = SRC_PLAN_R2;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/delimited_field_selector.sv */
// A word that releases no buffered bytes has its first result in the output register
// in the cycle after it is accepted. A word with no result or one result leaves the
// controller in ST_IDLE; a byte with a line marker passes ST_TAIL_R2. Released bytes go
// through ST_FLUSH_RD and ST_FLUSH_WR, as the buffer RAM has one read port, then the tail states.
// Reset (rst_n low, synchronous): registers to their defaults, line state cleared,
// output empty; buffer contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
// delimited_field_selector: streaming field / character selector
// Keeps selected character positions or delimited fields of each text line.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_field_selector
  import dfs_pkg::*;
#(
  parameter int MASK_POSITIONS    = 64,
  parameter int FIRST_FIELD_DEPTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t                      cfg;
  logic [MASK_POSITIONS-1:0] mask;
  cmd_t                      cmd;
  status_t                   status;

  dfs_regs #(
    .MASK_POSITIONS(MASK_POSITIONS)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg),
    .mask   (mask)
  );

  dfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  dfs_datapath #(
    .MASK_POSITIONS   (MASK_POSITIONS),
    .FIRST_FIELD_DEPTH(FIRST_FIELD_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .mask     (mask),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* design/dfs_checker.sv */
// ----------------------------------------------------------------------------
// dfs_checker: port-level checks for the delimited field selector
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_checker
  import dfs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // output empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // line markers carry no byte and close the word's results
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_BYTE) |-> out_data.last && (out_data.out_byte == 8'd0))
    else $error("line marker not last or carries a byte");

  // no new word while results of the previous one are still owed
  a_no_accept_midword: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input accepted while results still pending");

  // a word is only taken when the output register has room
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("input accepted with output register blocked");

endmodule

bind delimited_field_selector dfs_checker u_chk (.*);

`default_nettype wire
